// ===== sv/cpr_pkg.sv =====
package cpr_pkg;

    // Internal coordinate width: centre, x and y offsets
    localparam int COORD_BITS  = 10;
    // Fixed port field widths
    localparam int FIELD_W     = 10;
    localparam int RADIUS_W    = 9;
    localparam int PITCH_W     = 8;
    localparam int OFFSET_W    = 18;
    localparam int BIT_W       = 3;
    localparam int DEC_BITS    = 14;
    localparam int CFG_IDX_W   = 2;

    // Eight octant-mirrored points per item
    localparam int NUM_POINTS  = 8;
    localparam int PT_IDX_W    = 3;

    // Signed point coordinate: centre +/- offset plus a sign bit
    localparam int PCOORD_W    = COORD_BITS + 2;
    // Stored on-screen coordinate: non-negative, up to twice the centre range
    localparam int SCOORD_W    = COORD_BITS + 1;
    localparam int PROD_W      = SCOORD_W + PITCH_W;
    localparam int SUM_W       = PROD_W + 1;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_PITCH     = 2'd2;

    localparam logic [FIELD_W-1:0] RST_SCREEN_WIDTH  = 10'd640;
    localparam logic [FIELD_W-1:0] RST_SCREEN_HEIGHT = 10'd400;
    localparam logic [PITCH_W-1:0] RST_ROW_PITCH     = 8'd80;

    // Decision constants of the midpoint recurrence
    localparam logic [DEC_BITS-1:0] DEC_START = 14'd3;
    localparam logic [DEC_BITS-1:0] DEC_INC_E = 14'd6;
    localparam logic [DEC_BITS-1:0] DEC_INC_SE = 14'd10;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } t_op;

    typedef struct packed {
        logic [FIELD_W-1:0] width;
        logic [FIELD_W-1:0] height;
        logic [PITCH_W-1:0] pitch;
    } t_screen_cfg;

    // One octant set to draw: centre, offset and completion flag
    typedef struct packed {
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  done;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_push;

endpackage

// ===== sv/cpr_front.sv =====
module cpr_front import cpr_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_full,
    input  t_op                 i_op,
    input  logic [FIELD_W-1:0]  i_center_x,
    input  logic [FIELD_W-1:0]  i_center_y,
    input  logic [RADIUS_W-1:0] i_radius,
    output logic                o_ready,
    output t_push               o_push
);

    logic [COORD_BITS-1:0] r_cx, r_cy, r_x, r_y;
    logic [COORD_BITS-1:0] n_cx, n_cy, n_x, n_y;
    logic [DEC_BITS-1:0]   r_dec, n_dec;
    logic                  r_active, n_active;
    logic                  accept;
    logic                  done;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_x      = r_x;
        n_y      = r_y;
        n_dec    = r_dec;
        n_active = r_active;
        o_push.valid = 1'b0;
        if (accept) begin
            case (i_op)
                OP_START: begin
                    n_cx  = COORD_BITS'(i_center_x);
                    n_cy  = COORD_BITS'(i_center_y);
                    n_x   = '0;
                    n_y   = COORD_BITS'(i_radius);
                    n_dec = DEC_START - (DEC_BITS'(n_y) << 1);
                    o_push.valid = 1'b1;
                end
                OP_STEP: begin
                    // step while idle: drop
                    if (r_active) begin
                        n_x = r_x + 1'b1;
                        if (r_dec[DEC_BITS-1]) begin
                            n_dec = r_dec + DEC_BITS'({n_x, 2'b00}) + DEC_INC_E;
                        end else begin
                            n_y   = r_y - 1'b1;
                            n_dec = r_dec + DEC_BITS'({n_x, 2'b00})
                                  - DEC_BITS'({n_y, 2'b00}) + DEC_INC_SE;
                        end
                        o_push.valid = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        done = !(n_x < n_y);
        if (o_push.valid) begin
            n_active = !done;
        end
        o_push.job.cx   = n_cx;
        o_push.job.cy   = n_cy;
        o_push.job.x    = n_x;
        o_push.job.y    = n_y;
        o_push.job.done = done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= '0;
            r_cy     <= '0;
            r_x      <= '0;
            r_y      <= '0;
            r_dec    <= '0;
            r_active <= 1'b0;
        end else begin
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_x      <= n_x;
            r_y      <= n_y;
            r_dec    <= n_dec;
            r_active <= n_active;
        end
    end

endmodule

// ===== sv/cpr_queue.sv =====
module cpr_queue import cpr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_valid,
    output t_job  o_job
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rptr];
    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_push.job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== sv/cpr_back.sv =====
module cpr_back import cpr_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_screen_cfg         i_cfg,
    input  logic                i_job_valid,
    input  t_job                i_job,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [OFFSET_W-1:0] o_byte_offset,
    output logic [BIT_W-1:0]    o_bit_index,
    output logic                o_last,
    output logic                o_done
);

    logic                  r_busy;
    logic [NUM_POINTS-1:0] r_mask, n_mask;
    logic [SCOORD_W-1:0]   r_col [NUM_POINTS];
    logic [SCOORD_W-1:0]   r_row [NUM_POINTS];
    logic                  r_done;

    logic                  r_ovalid;
    logic [OFFSET_W-1:0]   r_offset;
    logic [BIT_W-1:0]      r_bit;
    logic                  r_last, r_odone;

    logic signed [PCOORD_W-1:0] cx_s, cy_s, x_s, y_s;
    logic signed [PCOORD_W-1:0] pc [NUM_POINTS];
    logic signed [PCOORD_W-1:0] pr [NUM_POINTS];
    logic [NUM_POINTS-1:0]      load_mask;

    logic                  out_adv, emit, finish, load;
    logic [PT_IDX_W-1:0]   sel;
    logic [NUM_POINTS-1:0] remain;
    logic [SCOORD_W-1:0]   col, row;
    logic [PROD_W-1:0]     prod;
    logic [SUM_W-1:0]      sum;

    // Mirror the offset into the eight octants and flag the on-screen points
    always_comb begin
        cx_s = PCOORD_W'(i_job.cx);
        cy_s = PCOORD_W'(i_job.cy);
        x_s  = PCOORD_W'(i_job.x);
        y_s  = PCOORD_W'(i_job.y);
        pc[0] = cx_s - y_s;  pr[0] = cy_s - x_s;
        pc[1] = cx_s + y_s;  pr[1] = cy_s - x_s;
        pc[2] = cx_s - y_s;  pr[2] = cy_s + x_s;
        pc[3] = cx_s + y_s;  pr[3] = cy_s + x_s;
        pc[4] = cx_s - x_s;  pr[4] = cy_s - y_s;
        pc[5] = cx_s + x_s;  pr[5] = cy_s - y_s;
        pc[6] = cx_s - x_s;  pr[6] = cy_s + y_s;
        pc[7] = cx_s + x_s;  pr[7] = cy_s + y_s;
        for (int i = 0; i < NUM_POINTS; i++) begin
            load_mask[i] = !pc[i][PCOORD_W-1] && !pr[i][PCOORD_W-1]
                && (pc[i][SCOORD_W-1:0] < SCOORD_W'(i_cfg.width))
                && (pr[i][SCOORD_W-1:0] < SCOORD_W'(i_cfg.height));
        end
    end

    // Pick the lowest pending point
    always_comb begin
        sel = '0;
        for (int i = NUM_POINTS - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                sel = PT_IDX_W'(i);
            end
        end
        remain = r_mask & ~(NUM_POINTS'(1) << sel);
    end

    assign out_adv = !r_ovalid || i_ready;
    assign emit    = r_busy && (r_mask != '0) && out_adv;
    assign finish  = r_busy && ((r_mask == '0) || (emit && (remain == '0)));
    assign load    = i_job_valid && (!r_busy || finish);
    assign o_pop   = load;

    assign col  = r_col[sel];
    assign row  = r_row[sel];
    assign prod = PROD_W'(row) * PROD_W'(i_cfg.pitch);
    assign sum  = SUM_W'(prod) + SUM_W'(col >> 3);

    always_comb begin
        n_mask = r_mask;
        if (load) begin
            n_mask = load_mask;
        end else if (emit) begin
            n_mask = remain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            for (int i = 0; i < NUM_POINTS; i++) begin
                r_col[i] <= pc[i][SCOORD_W-1:0];
                r_row[i] <= pr[i][SCOORD_W-1:0];
            end
            r_done <= i_job.done;
        end
        if (emit) begin
            r_offset <= sum[OFFSET_W-1:0];
            r_bit    <= BIT_W'(3'd7 - col[2:0]);
            r_last   <= (remain == '0);
            r_odone  <= r_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_mask   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_mask <= n_mask;
            if (load) begin
                r_busy <= 1'b1;
            end else if (finish) begin
                r_busy <= 1'b0;
            end
            if (out_adv) begin
                r_ovalid <= emit;
            end
        end
    end

    assign o_valid       = r_ovalid;
    assign o_byte_offset = r_offset;
    assign o_bit_index   = r_bit;
    assign o_last        = r_last;
    assign o_done        = r_odone;

endmodule

// ===== sv/circle_point_rasterizer_core.sv =====
// Midpoint circle rasterizer: turns circle commands into frame buffer
// set-requests for a 1-bit-per-pixel display.
//
// Input stream (s_axis): tuser is the operation, start (0) or step (1).
// A start loads centre and radius and emits the points at offset (0, r);
// each step advances x by one and emits the next eight mirrored points.
// A step with no circle in progress is accepted and produces nothing.
// Output stream (m_axis): one beat per on-screen point, carrying the byte
// offset and bit index; tlast marks the final beat of an input item and
// tuser flags beats of the item that completes the circle. Items whose
// points all fall off screen give no beats.
// An item passes through the queue and the generator's point mask, and
// each beat through the output register; the generator emits one beat per
// cycle while the receiver does not stall, eight at most per item.
// A two-entry queue parts the command front end from the point generator,
// so commands are taken while earlier points still drain.
// When the receiver stalls, the output beat holds and the generator waits;
// commands back up into the queue, then tready falls.
// Reset clears the circle state, the queue and the output valid, and loads
// screen 640x400 with a row pitch of 80 bytes.
module circle_point_rasterizer_core import cpr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [FIELD_W-1:0]   i_cfg_wdata,
    // Command input
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [31:0]          i_s_axis_tdata,  // center_x[9:0], center_y[19:10], radius[28:20]
    input  logic [0:0]           i_s_axis_tuser,  // operation[0]
    // Pixel set-request output
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [23:0]          o_m_axis_tdata,  // byte_offset[17:0], bit_index[20:18]
    output logic                 o_m_axis_tlast,  // last_of_step
    output logic [0:0]           o_m_axis_tuser   // circle_done[0]
);

    t_screen_cfg         r_cfg;
    t_push               push;
    t_job                head_job;
    logic                q_full, q_valid, pop;
    logic [OFFSET_W-1:0] byte_offset;
    logic [BIT_W-1:0]    bit_index;
    logic                last_of_step, circle_done;
    t_op                 op;

    // Configuration registers: write only; the user must write them only while idle, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= RST_SCREEN_WIDTH;
            r_cfg.height <= RST_SCREEN_HEIGHT;
            r_cfg.pitch  <= RST_ROW_PITCH;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_SCREEN_WIDTH:  r_cfg.width  <= i_cfg_wdata;
                CFG_SCREEN_HEIGHT: r_cfg.height <= i_cfg_wdata;
                CFG_ROW_PITCH:     r_cfg.pitch  <= i_cfg_wdata[PITCH_W-1:0];
                default: ;
            endcase
        end
    end

    assign op = t_op'(i_s_axis_tuser[0]);

    // Front: decode commands and advance the midpoint recurrence
    cpr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .i_full     (q_full),
        .i_op       (op),
        .i_center_x (i_s_axis_tdata[9:0]),
        .i_center_y (i_s_axis_tdata[19:10]),
        .i_radius   (i_s_axis_tdata[28:20]),
        .o_ready    (o_s_axis_tready),
        .o_push     (push)
    );

    // Hold octant sets until the generator is free
    cpr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    // Back: clip and address one point per cycle while the output is not stalled
    cpr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_job_valid   (q_valid),
        .i_job         (head_job),
        .o_pop         (pop),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_byte_offset (byte_offset),
        .o_bit_index   (bit_index),
        .o_last        (last_of_step),
        .o_done        (circle_done)
    );

    assign o_m_axis_tdata = {3'b000, bit_index, byte_offset};
    assign o_m_axis_tlast = last_of_step;
    assign o_m_axis_tuser = circle_done;

endmodule

// ===== sv/cpr_checker.sv =====
module cpr_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata
);

    // Stalled beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output beat changed while stalled");

    // Reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // Reset empties the queue, so commands are taken at once
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_axis_tready)
        else $error("input not ready after reset");

    // Pad bits above bit_index stay clear
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[23:21] == 3'b000))
        else $error("output pad bits set");

endmodule

bind circle_point_rasterizer_core cpr_port_checker u_cpr_checker (.*);
